/* design/dad_pkg.sv */
// ----------------------------------------------------------------------------
// dad_pkg
// Shared types and constants of the detection anchor decoder.
// ----------------------------------------------------------------------------
package dad_pkg;

  localparam int MAX_CLASSES = 128;
  localparam int CLS_W       = $clog2(MAX_CLASSES);
  localparam int POS_W       = $clog2(MAX_CLASSES + 4);
  localparam int VAL_W       = 32;
  localparam int CC_W        = 8;
  localparam int THR_W       = 17;
  localparam int SCALE_W     = 24;
  localparam int PIX_W       = 16;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [1:0] REG_CLASS_COUNT = 2'd0;
  localparam logic [1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_INV_SCALE   = 2'd2;

  localparam logic [CC_W-1:0]    RST_CLASS_COUNT = CC_W'(80);
  localparam logic [THR_W-1:0]   RST_THRESHOLD   = THR_W'(16384);
  localparam logic [SCALE_W-1:0] RST_INV_SCALE   = SCALE_W'(65536);

  // What one element of an anchor row is.
  typedef enum logic [2:0] {
    EL_CX,
    EL_CY,
    EL_BW,
    EL_BH,
    EL_SCORE
  } elem_kind_t;

  typedef struct packed {
    elem_kind_t              kind;
    logic                    last;
    logic [CLS_W-1:0]        cls;
    logic signed [VAL_W-1:0] value;
  } qent_t;

  typedef struct packed {
    logic [CC_W-1:0]    class_count;
    logic [THR_W-1:0]   threshold;
    logic [SCALE_W-1:0] inv_scale;
  } cfg_t;

endpackage

/* design/detection_anchor_decode.sv */
// ----------------------------------------------------------------------------
// detection_anchor_decode
// Decodes detector anchor rows into one box with label and confidence.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one signed Q15.16 element per transfer: centre x,
// centre y, width, height, then class_count class scores. The block accepts
// one element every cycle while its four-entry queue has room; in_stall is
// high only while that queue is full.
// The result channel carries at most one item per row, after the row's last
// score and only when the best score reaches the threshold. A last score
// passes through the queue, the end-of-row register and the output register.
// Box values go through a one-stage multiplier, and a row's last score waits
// in the queue until the output register can take its result, so a stalled
// receiver fills the queue and then stalls the sender. Rows of at least five
// elements never limit the rate while out_stall is low: one element a cycle.
// The configuration port is written with psel, penable, pwrite and pready
// high; write it only while no row is in progress in the pipeline.
// Reset clears the row position, the argmax, the anchor count and both
// handshakes, and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module detection_anchor_decode import dad_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_AW-1:0]       paddr,
  input  logic [CFG_DW-1:0]       pwdata,
  output logic [CFG_DW-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PIX_W-1:0]        out_box_left,
  output logic [PIX_W-1:0]        out_box_top,
  output logic [PIX_W-1:0]        out_box_width,
  output logic [PIX_W-1:0]        out_box_height,
  output logic [CLS_W-1:0]        out_class_label,
  output logic signed [VAL_W-1:0] out_confidence,
  output logic [PIX_W-1:0]        out_anchor_number
);

  cfg_t       cfg_r;
  logic [1:0] reg_idx;
  logic       push, pop, q_empty, q_full;
  qent_t      push_data, head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.class_count <= RST_CLASS_COUNT;
      cfg_r.threshold   <= RST_THRESHOLD;
      cfg_r.inv_scale   <= RST_INV_SCALE;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_CLASS_COUNT: cfg_r.class_count <= pwdata[CC_W-1:0];
        REG_THRESHOLD:   cfg_r.threshold   <= pwdata[THR_W-1:0];
        REG_INV_SCALE:   cfg_r.inv_scale   <= pwdata[SCALE_W-1:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CLASS_COUNT: prdata = CFG_DW'(cfg_r.class_count);
      REG_THRESHOLD:   prdata = CFG_DW'(cfg_r.threshold);
      REG_INV_SCALE:   prdata = CFG_DW'(cfg_r.inv_scale);
      default:         prdata = '0;
    endcase
  end

  assign in_stall = q_full;

  dad_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_value  (in_value),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  dad_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  dad_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head              (head),
    .q_empty           (q_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_box_left      (out_box_left),
    .out_box_top       (out_box_top),
    .out_box_width     (out_box_width),
    .out_box_height    (out_box_height),
    .out_class_label   (out_class_label),
    .out_confidence    (out_confidence),
    .out_anchor_number (out_anchor_number)
  );

endmodule

/* design/dad_front.sv */
// ----------------------------------------------------------------------------
// dad_front
// Accepts row elements, tracks the position in the row and tags each
// element as a box value or a class score.
// ----------------------------------------------------------------------------
module dad_front import dad_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    q_full,
  output logic                    push,
  output qent_t                   push_data
);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [CC_W-1:0]  cc_eff;
  logic [POS_W-1:0] last_pos;

  assign push = in_valid && !q_full;

  always_comb begin
    if (cfg.class_count == '0) begin
      cc_eff = CC_W'(1);
    end else if (cfg.class_count > CC_W'(MAX_CLASSES)) begin
      cc_eff = CC_W'(MAX_CLASSES);
    end else begin
      cc_eff = cfg.class_count;
    end
    last_pos = POS_W'(cc_eff) + POS_W'(3);
  end

  always_comb begin
    push_data.value = in_value;
    push_data.cls   = CLS_W'(pos_r - POS_W'(4));
    push_data.last  = 1'b0;
    pos_nxt         = pos_r;
    case (pos_r)
      POS_W'(0): push_data.kind = EL_CX;
      POS_W'(1): push_data.kind = EL_CY;
      POS_W'(2): push_data.kind = EL_BW;
      POS_W'(3): push_data.kind = EL_BH;
      default:   push_data.kind = EL_SCORE;
    endcase
    if (pos_r >= POS_W'(4)) begin
      // A shortened count mid-row ends the row at the next score.
      push_data.last = pos_r >= last_pos;
    end
    if (push) begin
      pos_nxt = push_data.last ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

/* design/dad_fifo.sv */
// ----------------------------------------------------------------------------
// dad_fifo
// Short queue of tagged elements between the front and the back.
// ----------------------------------------------------------------------------
module dad_fifo import dad_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  input  logic  pop,
  output qent_t head,
  output logic  empty,
  output logic  full
);

  qent_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic [FIFO_AW:0]   cnt_nxt;

  assign head  = mem_r[rd_ptr_r];
  assign empty = cnt_r == '0;
  assign full  = cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (FIFO_AW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* design/dad_back.sv */
// ----------------------------------------------------------------------------
// dad_back
// Scales box values, keeps the running argmax and builds the result item
// at the end of each row.
// ----------------------------------------------------------------------------
module dad_back import dad_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  qent_t                   head,
  input  logic                    q_empty,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PIX_W-1:0]        out_box_left,
  output logic [PIX_W-1:0]        out_box_top,
  output logic [PIX_W-1:0]        out_box_width,
  output logic [PIX_W-1:0]        out_box_height,
  output logic [CLS_W-1:0]        out_class_label,
  output logic signed [VAL_W-1:0] out_confidence,
  output logic [PIX_W-1:0]        out_anchor_number
);

  localparam int PROD_W = VAL_W + SCALE_W + 1;
  localparam int SHF_W  = PROD_W - 16;

  // floor(c - s/2 + 0.5) clamped to the pixel range; never exceeds 16 bits.
  function automatic logic [PIX_W-1:0] edge_of(logic signed [VAL_W-1:0] c,
                                               logic signed [VAL_W-1:0] s);
    logic signed [VAL_W+1:0] t;
    t = ({{2{c[VAL_W-1]}}, c} <<< 1) - {{2{s[VAL_W-1]}}, s} + (VAL_W + 2)'(65536);
    return t[VAL_W+1] ? '0 : t[VAL_W:17];
  endfunction

  function automatic logic [PIX_W-1:0] size_of(logic signed [VAL_W-1:0] s);
    logic signed [VAL_W:0] t;
    t = {s[VAL_W-1], s} + (VAL_W + 1)'(32768);
    return t[VAL_W] ? '0 : t[VAL_W-1:16];
  endfunction

  // Multiply stage.
  logic                     mul_v_r;
  elem_kind_t               mul_kind_r;
  logic signed [PROD_W-1:0] mul_prod_r;

  // Scaled box values.
  logic signed [VAL_W-1:0] cx_r, cy_r, bw_r, bh_r;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SHF_W-1:0]  shf;
  logic signed [VAL_W-1:0]  scaled;

  // Argmax and end-of-row stage.
  logic signed [VAL_W-1:0] best_r, best_nxt;
  logic [CLS_W-1:0]        bcls_r, bcls_nxt;
  logic                    take;
  logic                    fin_v_r, fin_v_nxt;
  logic signed [VAL_W-1:0] fin_score_r;
  logic [CLS_W-1:0]        fin_cls_r;
  logic                    emit;
  logic [PIX_W-1:0]        anchor_r;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]        left_r, top_r, width_r, height_r, anum_r;
  logic [CLS_W-1:0]        label_r;
  logic signed [VAL_W-1:0] conf_r;

  // A row's last score leaves the queue only when the output register is
  // sure to be free for its result; this keeps the end stage one cycle long.
  always_comb begin
    pop = !q_empty;
    if (head.kind == EL_SCORE && head.last) begin
      pop = !q_empty && !fin_v_r && (!out_valid_r || !out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else begin
      mul_v_r <= pop && head.kind != EL_SCORE;
    end
  end

  always_ff @(posedge clk) begin
    mul_kind_r <= head.kind;
    mul_prod_r <= PROD_W'(head.value * $signed({1'b0, cfg.inv_scale}));
  end

  always_comb begin
    rnd = mul_prod_r + PROD_W'(32768);
    shf = SHF_W'(rnd >>> 16);
    if (shf[SHF_W-1:VAL_W-1] == '0 || shf[SHF_W-1:VAL_W-1] == '1) begin
      scaled = shf[VAL_W-1:0];
    end else if (shf[SHF_W-1]) begin
      scaled = {1'b1, {(VAL_W - 1){1'b0}}};
    end else begin
      scaled = {1'b0, {(VAL_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      bw_r <= '0;
      bh_r <= '0;
    end else if (mul_v_r) begin
      case (mul_kind_r)
        EL_CX:   cx_r <= scaled;
        EL_CY:   cy_r <= scaled;
        EL_BW:   bw_r <= scaled;
        EL_BH:   bh_r <= scaled;
        default: cx_r <= cx_r;
      endcase
    end
  end

  always_comb begin
    take      = (head.cls == '0) || (head.value > best_r);
    best_nxt  = best_r;
    bcls_nxt  = bcls_r;
    fin_v_nxt = 1'b0;
    if (pop && head.kind == EL_SCORE) begin
      if (take) begin
        best_nxt = head.value;
        bcls_nxt = head.cls;
      end
      fin_v_nxt = head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r   <= '0;
      bcls_r   <= '0;
      fin_v_r  <= 1'b0;
      anchor_r <= '0;
    end else begin
      best_r  <= best_nxt;
      bcls_r  <= bcls_nxt;
      fin_v_r <= fin_v_nxt;
      if (fin_v_r) begin
        anchor_r <= anchor_r + PIX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_v_nxt) begin
      fin_score_r <= best_nxt;
      fin_cls_r   <= bcls_nxt;
    end
  end

  assign emit = fin_v_r &&
                ($signed({fin_score_r[VAL_W-1], fin_score_r}) >=
                 $signed({{(VAL_W + 1 - THR_W){1'b0}}, cfg.threshold}));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      left_r   <= edge_of(cx_r, bw_r);
      top_r    <= edge_of(cy_r, bh_r);
      width_r  <= size_of(bw_r);
      height_r <= size_of(bh_r);
      label_r  <= fin_cls_r;
      conf_r   <= fin_score_r;
      anum_r   <= anchor_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_box_left      = left_r;
  assign out_box_top       = top_r;
  assign out_box_width     = width_r;
  assign out_box_height    = height_r;
  assign out_class_label   = label_r;
  assign out_confidence    = conf_r;
  assign out_anchor_number = anum_r;

endmodule

/* design/dad_checker.sv */
// ----------------------------------------------------------------------------
// dad_checker
// Port-level checks of the detection anchor decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dad_checker import dad_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    pready,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [PIX_W-1:0]        out_box_left,
  input logic signed [VAL_W-1:0] out_confidence,
  input logic [PIX_W-1:0]        out_anchor_number
);

  // The queue and the output register are empty right after reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result pending or input stalled after reset");

  // A held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_box_left) &&
      $stable(out_confidence) && $stable(out_anchor_number))
    else $error("stalled result changed");

  // A result right after a transfer comes from a later row.
  a_new_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid ||
      out_anchor_number != $past(out_anchor_number))
    else $error("one row gave two results");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port not ready");

endmodule

bind detection_anchor_decode dad_checker u_dad_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .pready            (pready),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_box_left      (out_box_left),
  .out_confidence    (out_confidence),
  .out_anchor_number (out_anchor_number)
);

/* sim/detection_anchor_decode_tb.sv */
// ----------------------------------------------------------------------------
// detection_anchor_decode_tb
// Self-checking bench for the anchor row decoder: streams anchor rows through
// the block under random idling on both channels, predicts every box from its
// own fixed-point model of the row and compares each field of every result.
// ----------------------------------------------------------------------------
module detection_anchor_decode_tb;
  import dad_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_PAUSE = 12;
  localparam int PHASE_ITEMS = 85;

  typedef struct {
    logic [PIX_W-1:0]        left;
    logic [PIX_W-1:0]        top;
    logic [PIX_W-1:0]        width;
    logic [PIX_W-1:0]        height;
    logic [CLS_W-1:0]        label;
    logic signed [VAL_W-1:0] conf;
    logic [PIX_W-1:0]        anchor;
  } box_result_t;

  class anchor_scoreboard;
    logic [CC_W-1:0]    class_count;
    logic [THR_W-1:0]   threshold;
    logic [SCALE_W-1:0] inv_scale;

    int unsigned      pos;
    int               cx, cy, bw, bh;
    int               top_score;
    int unsigned      top_class;
    logic [PIX_W-1:0] row_count;

    box_result_t pending[$];
    int failures, checked, rows, elements;

    function new();
      class_count = RST_CLASS_COUNT;
      threshold   = RST_THRESHOLD;
      inv_scale   = RST_INV_SCALE;
      pos = 0;
      cx = 0; cy = 0; bw = 0; bh = 0;
      top_score = 0;
      top_class = 0;
      row_count = '0;
      failures = 0; checked = 0; rows = 0; elements = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_CLASS_COUNT: class_count = data[CC_W-1:0];
        REG_THRESHOLD:   threshold   = data[THR_W-1:0];
        REG_INV_SCALE:   inv_scale   = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // Out-of-range counts are clamped to the supported range.
    function int unsigned scores_per_row();
      int unsigned n;
      n = class_count;
      if (n < 1) n = 1;
      if (n > MAX_CLASSES) n = MAX_CLASSES;
      return n;
    endfunction

    // Q15.16 times Q8.16, rounded to nearest and saturated back to Q15.16.
    function int scaled(int v);
      longint p;
      p = longint'(v) * longint'(inv_scale) + 32768;
      p = p >>> 16;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      else if (p < -64'sd2147483648) p = -64'sd2147483648;
      return int'(p);
    endfunction

    // Rounded centre minus half size, computed at double resolution.
    function logic [PIX_W-1:0] side_px(int c, int s);
      longint t;
      t = 2 * longint'(c) - longint'(s) + 65536;
      if (t < 0) return '0;
      t = t >>> 17;
      return (t > 65535) ? 16'hFFFF : t[15:0];
    endfunction

    function logic [PIX_W-1:0] size_px(int s);
      longint t;
      t = longint'(s) + 32768;
      if (t < 0) return '0;
      t = t >>> 16;
      return (t > 65535) ? 16'hFFFF : t[15:0];
    endfunction

    function void take_element(logic signed [VAL_W-1:0] v);
      int unsigned last_pos;
      box_result_t r;
      elements++;
      last_pos = 3 + scores_per_row();
      if (pos < 4) begin
        case (pos)
          0: cx = scaled(v);
          1: cy = scaled(v);
          2: bw = scaled(v);
          default: bh = scaled(v);
        endcase
        pos++;
        return;
      end
      // Strict compare keeps the first of equal scores.
      if (pos == 4 || v > top_score) begin
        top_score = v;
        top_class = pos - 4;
      end
      if (pos >= last_pos) begin
        if (longint'(top_score) >= longint'(threshold)) begin
          r.left   = side_px(cx, bw);
          r.top    = side_px(cy, bh);
          r.width  = size_px(bw);
          r.height = size_px(bh);
          r.label  = top_class[CLS_W-1:0];
          r.conf   = top_score;
          r.anchor = row_count;
          pending.insert(pending.size(), r);
        end
        row_count = row_count + 1'b1;
        rows++;
        pos = 0;
      end else begin
        pos++;
      end
    endfunction

    function string show(box_result_t b);
      return $sformatf("left=%0d top=%0d w=%0d h=%0d label=%0d conf=%0d anchor=%0d",
                       b.left, b.top, b.width, b.height, b.label, b.conf, b.anchor);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("ERROR %0t: %s", $time, msg);
    endfunction

    function void check_result(box_result_t got);
      box_result_t want;
      if (pending.size() == 0) begin
        note_failure({"box arrived with none expected: ", show(got)});
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.left !== want.left || got.top !== want.top ||
          got.width !== want.width || got.height !== want.height ||
          got.label !== want.label || got.conf !== want.conf ||
          got.anchor !== want.anchor)
        note_failure({"box mismatch\n  expected ", show(want), "\n  actual   ", show(got)});
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CFG_AW-1:0]       paddr = '0;
  logic [CFG_DW-1:0]       pwdata = '0;
  logic [CFG_DW-1:0]       prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PIX_W-1:0]        out_box_left;
  logic [PIX_W-1:0]        out_box_top;
  logic [PIX_W-1:0]        out_box_width;
  logic [PIX_W-1:0]        out_box_height;
  logic [CLS_W-1:0]        out_class_label;
  logic signed [VAL_W-1:0] out_confidence;
  logic [PIX_W-1:0]        out_anchor_number;

  int send_idle = 0;
  int recv_idle = 0;

  anchor_scoreboard sb = new();

  detection_anchor_decode dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_box_left      (out_box_left),
    .out_box_top       (out_box_top),
    .out_box_width     (out_box_width),
    .out_box_height    (out_box_height),
    .out_class_label   (out_class_label),
    .out_confidence    (out_confidence),
    .out_anchor_number (out_anchor_number)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  always @(posedge clk) begin
    box_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.left   = out_box_left;
      got.top    = out_box_top;
      got.width  = out_box_width;
      got.height = out_box_height;
      got.label  = out_class_label;
      got.conf   = out_confidence;
      got.anchor = out_anchor_number;
      sb.check_result(got);
    end
  end

  // Ends the run if neither channel completes a transfer for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input int cc, input int thr, input int scale);
    cfg_write(REG_CLASS_COUNT, cc);
    cfg_write(REG_THRESHOLD, thr);
    cfg_write(REG_INV_SCALE, scale);
  endtask

  task automatic send_value(input logic signed [VAL_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_element(v);
  endtask

  // Holds the sender off until every predicted box is out, then lets a
  // row's last score that produced nothing clear the pipeline.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] box_value();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return -$signed({1'b0, 31'($urandom_range(0, 32'h0040_0000))});
      default: return $urandom_range(0, 32'h0280_0000);
    endcase
  endfunction

  task automatic send_row(input int unsigned n_scores);
    logic signed [VAL_W-1:0] v, prev;
    prev = '0;
    for (int i = 0; i < 4; i++) send_value(box_value());
    for (int unsigned k = 0; k < n_scores; k++) begin
      case ($urandom_range(0, 9))
        0, 1:    v = $urandom();
        2:       v = prev;
        default: v = $urandom_range(0, 32'h0002_0000);
      endcase
      send_value(v);
      prev = v;
    end
  endtask

  initial begin
    logic signed [VAL_W-1:0] row_extreme[5];
    logic signed [VAL_W-1:0] row_small[5];
    logic signed [VAL_W-1:0] row_tie[3];
    logic signed [VAL_W-1:0] row_cut[8];
    int start_elems;

    row_extreme = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000};
    row_small   = '{32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_0001,
                    32'h7FFF_FFFF};
    row_tie     = '{32'h0001_0000, 32'h0001_0000, 32'h0000_0005};
    row_cut     = '{32'h0064_0000, 32'h0032_0000, 32'h0010_8000, 32'h0008_0000,
                    32'h0000_8000, 32'h0003_0000, 32'h0003_0000, 32'hFFFF_FFFF};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Count of zero acts as one; widest scale saturates the box values.
    // The first row's score is below a zero threshold, the second is the
    // largest possible score.
    set_config(0, 0, 24'hFF_FFFF);
    foreach (row_extreme[i]) send_value(row_extreme[i]);
    foreach (row_small[i]) send_value(row_small[i]);

    // Zero scale flattens the box; equal top scores keep the lower class,
    // and a score exactly at the threshold still passes.
    wait_drained();
    set_config(3, 65536, 0);
    for (int i = 0; i < 4; i++) send_value($urandom());
    foreach (row_tie[i]) send_value(row_tie[i]);

    // Shrinking the class count mid-row ends the row at the next score.
    wait_drained();
    set_config(5, 16384, 65536);
    foreach (row_cut[i]) send_value(row_cut[i]);
    wait_drained();
    cfg_write(REG_CLASS_COUNT, 2);
    send_value(32'h0003_0001);

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      send_idle = (ph < 2) ? 28 : (ph < 4) ? 73 : 0;
      recv_idle = (ph < 2) ? 73 : (ph < 4) ? 28 : 0;
      case (ph)
        0: set_config(2, 0, 65536);
        1: set_config(255, $urandom_range(0, 131071), 24'hFF_FFFF);
        2: set_config($urandom_range(3, 12), 65536, $urandom_range(1, 24'hFF_FFFF));
        3: set_config(1, $urandom_range(0, 65536), 1);
        4: set_config($urandom_range(2, 8), $urandom_range(0, 65536),
                      $urandom_range(16384, 262144));
        default: set_config($urandom_range(1, 20), $urandom_range(0, 131071),
                            $urandom_range(1, 24'hFF_FFFF));
      endcase
      start_elems = sb.elements;
      while (sb.elements - start_elems < PHASE_ITEMS) send_row(sb.scores_per_row());
    end

    wait_drained();
    if (sb.pending.size() != 0)
      sb.note_failure($sformatf("%0d expected boxes never arrived", sb.pending.size()));
    $display("Streamed %0d elements in %0d anchor rows over ten register settings,",
             sb.elements, sb.rows);
    $display("checked %0d boxes under mixed, swapped and no idling on both channels.",
             sb.checked);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", sb.failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
